// File: sv/b64enc_pkg.sv
// ---------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the character map of the base64 encoder.
// ---------------------------------------------------------------------------
package b64enc_pkg;

   localparam int QueueDepth = 2;

   localparam logic [7:0] PadChar   = 8'h3D;
   localparam logic [7:0] PlusChar  = 8'h2B;
   localparam logic [7:0] SlashChar = 8'h2F;

   // byte position inside the current three-byte group
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;

   // one complete (or padded) group handed from front to back
   typedef struct packed {
      logic [23:0] bits;     // first byte in bits 23..16
      logic [1:0]  pad_cnt;  // number of trailing '=' characters
      logic        last;     // group closes the message
   } group_type;

   function automatic logic [7:0] b64_char(input logic [5:0] sextet);
      logic [7:0] s;
      s = {2'b00, sextet};
      if (sextet < 6'd26) begin
         return s + 8'h41;
      end else if (sextet < 6'd52) begin
         return s + 8'h47;  // 'a' - 26
      end else if (sextet < 6'd62) begin
         return s - 8'h04;  // '0' - 52
      end else if (sextet == 6'd62) begin
         return PlusChar;
      end else begin
         return SlashChar;
      end
   endfunction

endpackage

// File: sv/b64enc_front.sv
// ---------------------------------------------------------------------------
// b64enc_front
// Accepts message bytes, gathers them into groups and pushes each finished
// or padded group into the queue.
// ---------------------------------------------------------------------------
module b64enc_front
   import b64enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic       req_tlast,   // final_byte
   input  logic       q_full,
   output logic       q_push,
   output group_type  q_entry
);

   logic [1:0]  pos_ff, pos_in;
   logic [15:0] pend_ff, pend_in;
   logic        accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      pos_in          = pos_ff;
      pend_in         = pend_ff;
      q_push          = 1'b0;
      q_entry.bits    = {pend_ff, req_tdata};
      q_entry.pad_cnt = 2'd0;
      q_entry.last    = req_tlast;
      if (accept) begin
         case (pos_ff)
            POS_THIRD: begin
               q_push  = 1'b1;
               pos_in  = POS_FIRST;
               pend_in = 16'd0;
            end
            POS_SECOND: begin
               if (req_tlast) begin
                  q_push          = 1'b1;
                  q_entry.bits    = {pend_ff[15:8], req_tdata, 8'd0};
                  q_entry.pad_cnt = 2'd1;
                  pos_in          = POS_FIRST;
                  pend_in         = 16'd0;
               end else begin
                  pend_in = {pend_ff[15:8], req_tdata};
                  pos_in  = POS_THIRD;
               end
            end
            default: begin
               // unreachable fourth position behaves as the first
               if (req_tlast) begin
                  q_push          = 1'b1;
                  q_entry.bits    = {req_tdata, 16'd0};
                  q_entry.pad_cnt = 2'd2;
                  pos_in          = POS_FIRST;
                  pend_in         = 16'd0;
               end else begin
                  pend_in = {req_tdata, 8'd0};
                  pos_in  = POS_SECOND;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_FIRST;
         pend_ff <= 16'd0;
      end else begin
         pos_ff  <= pos_in;
         pend_ff <= pend_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff != 2'd3)
      else $error("group position left its range");

endmodule

// File: sv/b64enc_queue.sv
// ---------------------------------------------------------------------------
// b64enc_queue
// Small group queue between front and back.
// ---------------------------------------------------------------------------
module b64enc_queue
   import b64enc_pkg::*;
#(
   parameter int DEPTH = QueueDepth
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      q_valid,
   output group_type head
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   group_type       mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign full    = count_ff == CntW'(DEPTH);
   assign q_valid = count_ff != '0;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("group queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("group queue underflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("group queue count out of range");

endmodule

// File: sv/b64enc_back.sv
// ---------------------------------------------------------------------------
// b64enc_back
// Turns each queued group into four characters, one per cycle while
// rsp_tready does not stall it, through a registered output stage.
// ---------------------------------------------------------------------------
module b64enc_back
   import b64enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  group_type  head,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_char
   output logic       rsp_tlast    // end_of_message
);

   group_type  grp_ff, grp_in;
   logic [1:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       out_free;
   logic [5:0] sextet;
   logic       is_pad;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = grp_ff.bits[23:18];
         2'd1:    sextet = grp_ff.bits[17:12];
         2'd2:    sextet = grp_ff.bits[11:6];
         default: sextet = grp_ff.bits[5:0];
      endcase
   end

   // pad once index + pad count reaches four
   assign is_pad = ({1'b0, idx_ff} + {1'b0, grp_ff.pad_cnt}) >= 3'd4;

   assign pop = q_valid && (!busy_ff || (out_free && idx_ff == 2'd3));

   always_comb begin
      grp_in   = grp_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (out_free) begin
         valid_in = busy_ff;
         data_in  = is_pad ? PadChar : b64_char(sextet);
         last_in  = grp_ff.last && idx_ff == 2'd3;
         if (busy_ff) begin
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               busy_in = 1'b0;
            end
         end
      end
      if (pop) begin
         grp_in  = head;
         idx_in  = 2'd0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff  <= grp_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> idx_ff == 2'd0)
      else $error("character index moved while idle");

   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      pop && busy_ff |-> idx_ff == 2'd3 && out_free)
      else $error("group loaded before previous group finished");

endmodule

// File: sv/base64_stream_encoder.sv
// ---------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder with standard alphabet and '=' padding.
// ---------------------------------------------------------------------------
// Bytes enter one per transaction on req_, with req_tlast on the final byte
// of a message; characters leave one per transaction on rsp_, with rsp_tlast
// on the last character of the encoded message. Each group of three bytes,
// or the shorter group closed by a final byte, becomes four characters.
// The single character output sets the sustained rate: one character per
// cycle while rsp_tready does not stall it. A group closed by a byte passes
// through the queue and the back end's group register before its first
// character is registered at the output. A queue of QUEUE_DEPTH groups
// sits between byte intake and character output, so bytes keep flowing
// while characters wait on rsp_tready, until the queue fills.
// ---------------------------------------------------------------------------
module base64_stream_encoder
   import b64enc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepth
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // final_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast    // end_of_message
);

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_valid;
   group_type push_entry;
   group_type head;

   b64enc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   b64enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .q_valid    (q_valid),
      .head       (head)
   );

   b64enc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head       (head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: sim/b64enc_char_checker.sv
// ---------------------------------------------------------------------------
// b64enc_char_checker
// Watches both streams of the base64 encoder and checks every character.
// ---------------------------------------------------------------------------
// Each byte transaction on req_ is run through a local encoder that holds
// its own pending bytes and group position; completed or closed groups push
// four characters into a queue. Each character transaction on rsp_ is
// compared with the oldest queued character and its end-of-message flag.
// ---------------------------------------------------------------------------
module b64enc_char_checker
   import b64enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // final_byte
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] out_char
   input  logic       rsp_tlast,   // end_of_message
   output int         fail_count,
   output int         pending_chars
);

   typedef struct packed {
      logic [7:0] ch;
      logic       eom;
   } enc_char_type;

   logic [7:0]   alphabet [0:63];
   enc_char_type char_q [$];
   logic [15:0]  held_bytes;
   logic [1:0]   group_pos;

   initial begin
      for (int i = 0; i < 26; i++) begin
         alphabet[i]      = 8'h41 + i[7:0];
         alphabet[i + 26] = 8'h61 + i[7:0];
      end
      for (int i = 0; i < 10; i++) begin
         alphabet[i + 52] = 8'h30 + i[7:0];
      end
      alphabet[62] = PlusChar;
      alphabet[63] = SlashChar;
      fail_count    = 0;
      pending_chars = 0;
   end

   // characters beyond n_real are padding
   task automatic push_group(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input int n_real,
                             input logic fin);
      logic [5:0]   sx [0:3];
      enc_char_type item;
      sx[0] = b0[7:2];
      sx[1] = {b0[1:0], b1[7:4]};
      sx[2] = {b1[3:0], b2[7:6]};
      sx[3] = b2[5:0];
      for (int k = 0; k < 4; k++) begin
         item.ch  = (k < n_real) ? alphabet[sx[k]] : PadChar;
         item.eom = (k == 3) && fin;
         char_q.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_bytes = '0;
         group_pos  = POS_FIRST;
         char_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (group_pos == POS_THIRD) begin
               push_group(held_bytes[15:8], held_bytes[7:0], req_tdata, 4, req_tlast);
               held_bytes = '0;
               group_pos  = POS_FIRST;
            end else if (req_tlast) begin
               // a stray position three behaves as the first position
               if (group_pos == POS_SECOND) begin
                  push_group(held_bytes[15:8], req_tdata, 8'h00, 3, 1'b1);
               end else begin
                  push_group(req_tdata, 8'h00, 8'h00, 2, 1'b1);
               end
               held_bytes = '0;
               group_pos  = POS_FIRST;
            end else if (group_pos == POS_SECOND) begin
               held_bytes[7:0] = req_tdata;
               group_pos       = POS_THIRD;
            end else begin
               held_bytes = {req_tdata, 8'h00};
               group_pos  = POS_SECOND;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (char_q.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected character %h tlast %b", rsp_tdata, rsp_tlast);
               end
               fail_count++;
            end else begin
               if (char_q[0].ch !== rsp_tdata || char_q[0].eom !== rsp_tlast) begin
                  if (fail_count < 10) begin
                     $display("character mismatch: expected %h tlast %b, got %h tlast %b",
                              char_q[0].ch, char_q[0].eom, rsp_tdata, rsp_tlast);
                  end
                  fail_count++;
               end
               void'(char_q.pop_front());
            end
         end
      end
      pending_chars = char_q.size();
   end

endmodule

// File: sim/base64_stream_encoder_tb.sv
// ---------------------------------------------------------------------------
// base64_stream_encoder_tb
// Stimulus and verdict for the streaming base64 encoder.
// ---------------------------------------------------------------------------
// A short directed set covers padding after one and two bytes, full groups,
// the '+' and '/' characters and back-to-back one-byte messages. Random
// messages follow in four phases of sender idling and receiver stalling,
// the sender draining all outstanding characters between phases.
// ---------------------------------------------------------------------------
module base64_stream_encoder_tb;

   localparam int WatchdogLimit = 2000;
   localparam int ItemsPerPhase = 50;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;  // [7:0] data_byte
   logic       req_tlast  = 1'b0;   // final_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_char
   logic       rsp_tlast;           // end_of_message

   int fail_count;
   int pending_chars;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int quiet_cycles   = 0;
   int bytes_in_phase;

   always #1 clock = ~clock;

   base64_stream_encoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   b64enc_char_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_chars (pending_chars)
   );

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_byte(input logic [7:0] data, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = data;
      req_tlast  = fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      bytes_in_phase++;
   endtask

   task automatic send_message(input int len);
      logic [7:0] data;
      int         pick;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            data = 8'h00;
         end else if (pick < 10) begin
            data = 8'hFF;
         end else begin
            data = $urandom_range(255);
         end
         send_byte(data, i == len - 1);
      end
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_chars != 0) @(negedge clock);
   endtask

   initial begin
      int pick;
      int len;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // one-byte messages: two characters and two pads
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // two-byte message: three characters and one pad
      send_byte(8'h66, 1'b0);
      send_byte(8'h6F, 1'b1);
      // full group closing the message
      send_byte(8'h66, 1'b0);
      send_byte(8'h6F, 1'b0);
      send_byte(8'h6F, 1'b1);
      // "+/+/" group mid-message, then a final byte opening a new group
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'h00, 1'b1);
      // all-ones two-byte message
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      // final flags back to back
      send_byte(8'h41, 1'b1);
      send_byte(8'h42, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 65; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 65; end
            default: begin send_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         bytes_in_phase = 0;
         while (bytes_in_phase < ItemsPerPhase) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               len = $urandom_range(6, 1);
            end else if (pick < 95) begin
               len = $urandom_range(16, 7);
            end else begin
               len = $urandom_range(40, 17);
            end
            send_message(len);
         end
         // hold off until every outstanding character has arrived
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_chars == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
